@@ rtl/bpq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared constants, result codes and the controller command bundle of the
// bucketed priority queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

	localparam int NUM_LEVELS_DEF  = 10;
	localparam int LEVEL_DEPTH_DEF = 16;

	// fixed field widths of the request and result
	localparam int DATA_WIDTH  = 16;
	localparam int PRI_WIDTH   = 4;
	localparam int COUNT_WIDTH = 8;
	localparam int STAT_WIDTH  = 2;

	typedef enum logic [STAT_WIDTH-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPRI = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;   // take a request into the datapath
		logic exec;      // run the pointer update and memory access
		logic load_out;  // move the result into the output register
	} bpq_cmd_t;

endpackage
`default_nettype wire

@@ rtl/bpq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_ctrl
// Request sequencer: accept, execute, then hand the result to the output
// register while taking the next request.
// ----------------------------------------------------------------------------
module bpq_ctrl
	import bpq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	output bpq_cmd_t      cmd
);

	typedef enum logic [1:0] {
		IDLE,
		EXEC,
		DONE
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   can_load;
	logic   accept;

	// output register is free or being emptied this cycle
	assign can_load = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == IDLE) || ((state_q == DONE) && can_load);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd.capture  = accept;
		cmd.exec     = (state_q == EXEC);
		cmd.load_out = (state_q == DONE) && can_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= EXEC;
					end
				end
				EXEC: begin
					state_q <= DONE;
				end
				DONE: begin
					if (can_load) begin
						state_q <= accept ? EXEC : IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/bpq_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_datapath
// Per-level head, tail and fill registers, level priority encoder, shared
// payload memory and the result registers.
// ----------------------------------------------------------------------------
module bpq_datapath
	import bpq_pkg::*;
#(
	parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire bpq_cmd_t               cmd,
	input  wire logic                   req_type,
	input  wire logic [PRI_WIDTH-1:0]   priority_req,
	input  wire logic [DATA_WIDTH-1:0]  item,
	output logic [DATA_WIDTH-1:0]       popped_item,
	output logic                        popped_valid,
	output logic [STAT_WIDTH-1:0]       status,
	output logic                        queue_empty,
	output logic [COUNT_WIDTH-1:0]      total_count
);

	localparam int SLOTS = NUM_LEVELS * LEVEL_DEPTH;
	localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int PW    = $clog2(LEVEL_DEPTH);
	localparam int FW    = $clog2(LEVEL_DEPTH + 1);
	localparam int TW    = $clog2(SLOTS + 1);
	localparam int AW    = $clog2(SLOTS);

	// request registers
	logic                  pop_q;
	logic [PRI_WIDTH-1:0]  pri_q;
	logic [DATA_WIDTH-1:0] item_q;

	// level bookkeeping
	logic [PW-1:0] head_q [NUM_LEVELS];
	logic [PW-1:0] tail_q [NUM_LEVELS];
	logic [FW-1:0] fill_q [NUM_LEVELS];
	logic [TW-1:0] total_q;

	// result of the execute step
	status_t               stat_q;
	logic                  valid_q;
	logic [DATA_WIDTH-1:0] rd_q;

	// output register
	logic [DATA_WIDTH-1:0]  out_item_q;
	logic                   out_valid_q;
	logic [STAT_WIDTH-1:0]  out_stat_q;
	logic                   out_empty_q;
	logic [COUNT_WIDTH-1:0] out_total_q;

	logic [DATA_WIDTH-1:0] mem [SLOTS];

	logic [NUM_LEVELS-1:0] nonempty;
	logic [LW-1:0]         pop_lv;
	logic                  any_item;
	logic [31:0]           pri_ext;
	logic                  pri_ok;
	logic [LW-1:0]         lv;
	logic                  lv_full;
	logic [PW-1:0]         pos;
	logic [PW-1:0]         pos_nxt;
	logic [AW-1:0]         addr;
	status_t               stat_d;
	logic                  do_write;
	logic                  do_read;
	logic [TW-1:0]         total_nxt;
	logic [31:0]           total_ext;

	always_comb begin
		for (int i = 0; i < NUM_LEVELS; i++) begin
			nonempty[i] = (fill_q[i] != '0);
		end
	end

	// lowest-numbered nonempty level wins
	always_comb begin
		pop_lv = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (nonempty[i]) begin
				pop_lv = LW'(i);
			end
		end
	end

	assign any_item = |nonempty;
	assign pri_ext  = 32'(pri_q);
	assign pri_ok   = (pri_ext != 32'd0) && (pri_ext <= 32'(NUM_LEVELS));

	always_comb begin
		if (pop_q) begin
			lv = pop_lv;
		end else if (pri_ok) begin
			lv = LW'(pri_ext - 32'd1);
		end else begin
			lv = '0;
		end
	end

	assign lv_full = (fill_q[lv] == FW'(LEVEL_DEPTH));
	assign pos     = pop_q ? head_q[lv] : tail_q[lv];
	assign pos_nxt = (pos == PW'(LEVEL_DEPTH - 1)) ? '0 : pos + PW'(1);
	assign addr    = AW'(lv) * AW'(LEVEL_DEPTH) + AW'(pos);

	always_comb begin
		priority if (pop_q) begin
			stat_d = any_item ? ST_OK : ST_EMPTY;
		end else if (!pri_ok) begin
			stat_d = ST_BADPRI;
		end else if (lv_full) begin
			stat_d = ST_FULL;
		end else begin
			stat_d = ST_OK;
		end
	end

	assign do_write = cmd.exec && !pop_q && (stat_d == ST_OK);
	assign do_read  = cmd.exec && pop_q && (stat_d == ST_OK);

	always_comb begin
		total_nxt = total_q;
		if (do_write) begin
			total_nxt = total_q + TW'(1);
		end else if (do_read) begin
			total_nxt = total_q - TW'(1);
		end
	end

	assign total_ext = 32'(total_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pop_q  <= req_type;
			pri_q  <= priority_req;
			item_q <= item;
		end
		if (cmd.exec) begin
			stat_q  <= stat_d;
			valid_q <= do_read;
		end
		if (cmd.load_out) begin
			out_item_q  <= valid_q ? rd_q : '0;
			out_valid_q <= valid_q;
			out_stat_q  <= stat_q;
			out_empty_q <= (total_q == '0);
			out_total_q <= total_ext[COUNT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[addr] <= item_q;
		end
		if (do_read) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			total_q <= '0;
		end else begin
			if (do_write) begin
				tail_q[lv] <= pos_nxt;
				fill_q[lv] <= fill_q[lv] + FW'(1);
			end
			if (do_read) begin
				head_q[lv] <= pos_nxt;
				fill_q[lv] <= fill_q[lv] - FW'(1);
			end
			total_q <= total_nxt;
		end
	end

	assign popped_item  = out_item_q;
	assign popped_valid = out_valid_q;
	assign status       = out_stat_q;
	assign queue_empty  = out_empty_q;
	assign total_count  = out_total_q;

endmodule
`default_nettype wire

@@ rtl/bucketed_priority_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_priority_queue
// Priority queue built from one FIFO per level over a shared payload memory.
// ----------------------------------------------------------------------------
// Each request (insert or pop) is first latched, then the execute step does
// the level pointer update and the single access to the synchronous payload
// memory, whose registered read data then goes to the output register while
// the next request is accepted. Every request returns exactly one result. A
// pop takes the oldest item of the lowest-numbered nonempty level, found by a
// priority encoder over the level fill counters. Errors are reported in the
// status field and leave the queue unchanged. total_count is the number of
// held items after the request, kept to its low eight bits.
module bucketed_priority_queue
	import bpq_pkg::*;
#(
	parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // priority_req[3:0], item[19:4], zero pad
	input  wire logic        s_tuser,   // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // popped_item[15:0], status[17:16],
	                                    // queue_empty[18], total_count[26:19], zero pad
	output logic             m_tuser    // popped_valid
);

	bpq_cmd_t               cmd;
	logic [DATA_WIDTH-1:0]  popped_item;
	logic                   popped_valid;
	logic [STAT_WIDTH-1:0]  status;
	logic                   queue_empty;
	logic [COUNT_WIDTH-1:0] total_count;

	bpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	bpq_datapath #(
		.NUM_LEVELS  (NUM_LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_type     (s_tuser),
		.priority_req (s_tdata[PRI_WIDTH-1:0]),
		.item         (s_tdata[PRI_WIDTH+DATA_WIDTH-1:PRI_WIDTH]),
		.popped_item  (popped_item),
		.popped_valid (popped_valid),
		.status       (status),
		.queue_empty  (queue_empty),
		.total_count  (total_count)
	);

	assign m_tdata = {5'd0, total_count, queue_empty, status, popped_item};
	assign m_tuser = popped_valid;

	// a delivered payload always comes with an ok code
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (status == ST_OK))
		else $error("popped payload with error status");

	// a request is never followed by another in the next cycle
	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted during execute");

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

endmodule
`default_nettype wire

@@ verif/bpq_checker.sv @@
// ----------------------------------------------------------------------------
// bpq_checker
// Watches both stream channels of the bucketed priority queue. Every accepted
// request runs through a behavioral copy of the per-level FIFOs, and the
// predicted outcome waits in order until the matching result is accepted and
// compared field by field.
// ----------------------------------------------------------------------------
package bpq_tb_pkg;

	// s_tuser encoding of the request kind
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_POP    = 1'b1;

endpackage

module bpq_checker
	import bpq_pkg::*;
	import bpq_tb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [23:0] s_tdata,   // priority_req[3:0], item[19:4], zero pad
	input  wire logic        s_tuser,   // req_type
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,   // popped_item[15:0], status[17:16],
	                                    // queue_empty[18], total_count[26:19], zero pad
	input  wire logic        m_tuser,   // popped_valid
	output int               fail_count,
	output int               pending,
	output int               data_pops,
	output int               empty_pops,
	output int               full_drops,
	output int               badpri_drops,
	output int               peak_held
);

	typedef struct {
		logic [DATA_WIDTH-1:0]  item;
		logic                   valid;
		status_t                status;
		logic                   empty;
		logic [COUNT_WIDTH-1:0] total;
	} outcome_t;

	logic [DATA_WIDTH-1:0] payload_mem [NUM_LEVELS_DEF][LEVEL_DEPTH_DEF];
	int head_pos [NUM_LEVELS_DEF] = '{default: 0};
	int tail_pos [NUM_LEVELS_DEF] = '{default: 0};
	int fill_cnt [NUM_LEVELS_DEF] = '{default: 0};
	int held = 0;
	int errs = 0;
	int results_seen = 0;
	int pend_cnt = 0;
	int n_data_pops = 0, n_empty_pops = 0, n_full = 0, n_badpri = 0, n_peak = 0;
	outcome_t outcome_q[$];

	assign fail_count   = errs;
	assign pending      = pend_cnt;
	assign data_pops    = n_data_pops;
	assign empty_pops   = n_empty_pops;
	assign full_drops   = n_full;
	assign badpri_drops = n_badpri;
	assign peak_held    = n_peak;

	// applies one request to the level FIFOs and returns what the block should report
	function automatic outcome_t queue_apply(logic op, logic [PRI_WIDTH-1:0] pri,
			logic [DATA_WIDTH-1:0] data);
		outcome_t r;
		int lv;
		r.item   = '0;
		r.valid  = 1'b0;
		r.status = ST_OK;
		lv = -1;
		if (op == REQ_INSERT) begin
			if (pri == 0 || pri > NUM_LEVELS_DEF) begin
				r.status = ST_BADPRI;
			end else if (fill_cnt[pri-1] >= LEVEL_DEPTH_DEF) begin
				r.status = ST_FULL;
			end else begin
				lv = int'(pri) - 1;
				payload_mem[lv][tail_pos[lv]] = data;
				tail_pos[lv] = (tail_pos[lv] + 1) % LEVEL_DEPTH_DEF;
				fill_cnt[lv]++;
				held++;
			end
		end else begin
			// lowest-numbered nonempty level wins
			for (int i = NUM_LEVELS_DEF - 1; i >= 0; i--)
				if (fill_cnt[i] != 0)
					lv = i;
			if (lv < 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.item  = payload_mem[lv][head_pos[lv]];
				r.valid = 1'b1;
				head_pos[lv] = (head_pos[lv] + 1) % LEVEL_DEPTH_DEF;
				fill_cnt[lv]--;
				held--;
			end
		end
		r.empty = (held == 0);
		r.total = COUNT_WIDTH'(held);
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
			$time, results_seen, field, got, want);
		errs++;
	endtask

	always @(posedge clk) begin : watch
		outcome_t want;
		outcome_t fresh;
		if (arst_n) begin
			// results first, so a result never meets the request accepted on its own edge
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (outcome_q.size() == 0) begin
					report_mismatch("result with no request pending", m_tdata, '0);
				end else begin
					want = outcome_q.pop_front();
					if (m_tdata[15:0] !== want.item)
						report_mismatch("popped_item", 32'(m_tdata[15:0]),
							32'(want.item));
					if (m_tuser !== want.valid)
						report_mismatch("popped_valid", 32'(m_tuser), 32'(want.valid));
					if (m_tdata[17:16] !== want.status)
						report_mismatch("status", 32'(m_tdata[17:16]),
							32'(want.status));
					if (m_tdata[18] !== want.empty)
						report_mismatch("queue_empty", 32'(m_tdata[18]), 32'(want.empty));
					if (m_tdata[26:19] !== want.total)
						report_mismatch("total_count", 32'(m_tdata[26:19]),
							32'(want.total));
				end
			end
			if (s_tvalid && s_tready) begin
				fresh = queue_apply(s_tuser, s_tdata[3:0], s_tdata[19:4]);
				case (fresh.status)
					ST_OK:     if (fresh.valid) n_data_pops++;
					ST_EMPTY:  n_empty_pops++;
					ST_FULL:   n_full++;
					ST_BADPRI: n_badpri++;
					default:   ;
				endcase
				if (held > n_peak)
					n_peak = held;
				outcome_q.push_back(fresh);
			end
			pend_cnt = outcome_q.size();
		end
	end

endmodule

@@ verif/bucketed_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// bucketed_priority_queue_tb
// Drives insert and pop requests into the queue with random gaps and result
// stalls, and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module bucketed_priority_queue_tb;
	import bpq_pkg::*;
	import bpq_tb_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 16;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        s_tuser  = REQ_INSERT;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;

	int fail_count, pending, data_pops, empty_pops, full_drops, badpri_drops, peak_held;
	int sent = 0;
	int cycles = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;

	bucketed_priority_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	bpq_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.pending      (pending),
		.data_pops    (data_pops),
		.empty_pops   (empty_pops),
		.full_drops   (full_drops),
		.badpri_drops (badpri_drops),
		.peak_held    (peak_held)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles, pending);
			$display("[bucketed_priority_queue] ERROR");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= no_idle || ($urandom_range(99) >= 7);
			end
		end
	end

	// called at a rising edge; returns at the edge where the request is taken
	task automatic send(logic op, logic [PRI_WIDTH-1:0] pri, logic [DATA_WIDTH-1:0] data);
		if (!no_idle && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, data, pri};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic send_random(int n, int ins_pct, int lo_pri, int hi_pri);
		logic [PRI_WIDTH-1:0] pri;
		logic op;
		repeat (n) begin
			if ($urandom_range(99) < 6)
				pri = PRI_WIDTH'($urandom_range(0, 15));
			else
				pri = PRI_WIDTH'($urandom_range(lo_pri, hi_pri));
			op = ($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_POP;
			send(op, pri, DATA_WIDTH'($urandom));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty pop, bad levels, payload extremes, urgency order, one full level
		send(REQ_POP, 4'd0, 16'h0000);
		send(REQ_INSERT, 4'd0, 16'h1111);
		send(REQ_INSERT, 4'd11, 16'h2222);
		send(REQ_INSERT, 4'd15, 16'hFFFF);
		send(REQ_INSERT, 4'd10, 16'hFFFF);
		send(REQ_INSERT, 4'd1, 16'h0000);
		send(REQ_POP, 4'd10, 16'hFFFF);
		send(REQ_POP, 4'd0, 16'h0000);
		send(REQ_POP, 4'd0, 16'h0000);
		for (int k = 0; k <= LEVEL_DEPTH_DEF; k++)
			send(REQ_INSERT, 4'd3, DATA_WIDTH'(16'hA500 + k));

		send_random(300, 55, 1, 10);
		send_random(250, 85, 1, 10);

		// long result stall while requests keep coming, so the input backs up
		hold_req = 1'b1;
		send_random(60, 50, 1, 10);

		send_random(250, 20, 1, 10);

		no_idle = 1'b1;
		send_random(300, 60, 1, 2);
		no_idle = 1'b0;

		// let every outstanding result come back before going on
		s_tvalid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);

		send_random(390, 50, 1, 10);
		s_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests: %0d pops with data, %0d pops on empty, %0d full-level drops,",
			sent, data_pops, empty_pops, full_drops);
		$display("%0d bad-priority drops, peak of %0d items held", badpri_drops, peak_held);
		if (fail_count == 0)
			$display("[bucketed_priority_queue] OK");
		else
			$display("[bucketed_priority_queue] ERROR");
		$finish;
	end

endmodule
